// ===== hw/rtl/prf_pkg.sv =====
// Package for the power-of-two ring FIFO: operation codes, fixed field widths
// and the command control word passed from the front end to the back end.
// No dependencies.
package prf_pkg;

	localparam int COUNT_W         = 5;
	localparam int GRANT_W         = 5;
	localparam int SIZE_W          = 4;
	localparam int MAX_BURST       = 16;
	localparam int QUEUE_DEPTH     = 4;
	localparam logic [SIZE_W-1:0] SIZE_LOG2_RESET = 4'd10;

	typedef enum logic [1:0] {
		FUNC_WRITE   = 2'd0,
		FUNC_READ    = 2'd1,
		FUNC_DISCARD = 2'd2,
		FUNC_NOP     = 2'd3
	} func_t;

	typedef struct packed {
		logic               is_read;
		logic [GRANT_W-1:0] granted;
	} cmd_ctl_t;

endpackage

// ===== hw/rtl/prf_queue.sv =====
// Short command queue between the front end and the back end of the ring FIFO.
// Depends on prf_pkg for the queue depth.
module prf_queue #(
	parameter int WIDTH = 26
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] head_data
);
	import prf_pkg::*;

	localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] entry_q [QUEUE_DEPTH];
	logic [IW-1:0]    wr_idx_q;
	logic [IW-1:0]    rd_idx_q;
	logic [NW-1:0]    used_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (used_q == NW'(QUEUE_DEPTH));
	assign valid     = (used_q != '0);
	assign head_data = entry_q[rd_idx_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			used_q   <= '0;
		end else begin
			if (do_push) begin
				wr_idx_q <= (wr_idx_q == IW'(QUEUE_DEPTH - 1)) ? '0 : wr_idx_q + 1'b1;
			end
			if (do_pop) begin
				rd_idx_q <= (rd_idx_q == IW'(QUEUE_DEPTH - 1)) ? '0 : rd_idx_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				used_q <= used_q + 1'b1;
			end else if (do_pop && !do_push) begin
				used_q <= used_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_idx_q] <= push_data;
		end
	end

endmodule

// ===== hw/rtl/prf_front.sv =====
// Front end of the ring FIFO: size register, pointers, item acceptance,
// clamping of counts and command generation. Depends on prf_pkg.
module prf_front #(
	parameter int PW = 10,
	parameter int EW = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   func,
	input  logic [EW-1:0]                write_data,
	input  logic [prf_pkg::COUNT_W-1:0]  count,
	input  logic                         cfg_wr_en,
	input  logic [prf_pkg::SIZE_W-1:0]   cfg_wr_data,
	input  logic                         q_full,
	input  logic                         rd_done,
	output logic                         cmd_push,
	output prf_pkg::cmd_ctl_t            cmd_ctl,
	output logic [PW-1:0]                cmd_fill,
	output logic [PW-1:0]                cmd_ptr,
	output logic [PW-1:0]                ring_mask,
	output logic                         mem_we,
	output logic [PW-1:0]                mem_waddr,
	output logic [EW-1:0]                mem_wdata
);
	import prf_pkg::*;

	localparam int CW     = (PW > GRANT_W) ? PW : GRANT_W;
	localparam int PEND_W = $clog2(QUEUE_DEPTH + 2);

	logic [SIZE_W-1:0]  size_q;
	logic [PW-1:0]      rp_q;
	logic [PW-1:0]      wp_q;
	logic [PEND_W-1:0]  pend_q;

	logic [PW-1:0]      rp_m;
	logic [PW-1:0]      wp_m;
	logic [PW-1:0]      fill;
	logic [GRANT_W-1:0] req;
	logic [CW-1:0]      fill_c;
	logic [CW-1:0]      req_c;
	logic [CW-1:0]      n_c;
	logic [PW-1:0]      n_p;
	logic               full;
	logic               is_write;
	logic               accept;
	logic [PW-1:0]      rp_nx;
	logic [PW-1:0]      wp_nx;
	logic [PW-1:0]      fill_nx;
	logic [GRANT_W-1:0] grant;
	logic               is_read;

	always_comb begin
		for (int i = 0; i < PW; i++) begin
			ring_mask[i] = (i == 0) || (int'(size_q) > i);
		end
	end

	assign rp_m   = rp_q & ring_mask;
	assign wp_m   = wp_q & ring_mask;
	assign fill   = (wp_m - rp_m) & ring_mask;
	assign full   = (fill == ring_mask);
	assign req    = (count > COUNT_W'(MAX_BURST)) ? GRANT_W'(MAX_BURST) : GRANT_W'(count);
	assign fill_c = CW'(fill);
	assign req_c  = CW'(req);
	assign n_c    = (req_c < fill_c) ? req_c : fill_c;
	assign n_p    = PW'(n_c);

	always_comb begin
		rp_nx    = rp_m;
		wp_nx    = wp_m;
		fill_nx  = fill;
		grant    = '0;
		is_read  = 1'b0;
		is_write = 1'b0;
		case (func_t'(func))
			FUNC_WRITE: begin
				is_write = 1'b1;
				if (!full) begin
					wp_nx   = (wp_m + 1'b1) & ring_mask;
					fill_nx = fill + 1'b1;
					grant   = GRANT_W'(1);
				end
			end
			FUNC_READ: begin
				rp_nx   = (rp_m + n_p) & ring_mask;
				fill_nx = fill - n_p;
				grant   = GRANT_W'(n_c);
				is_read = (n_c != '0);
			end
			FUNC_DISCARD: begin
				rp_nx   = (rp_m + n_p) & ring_mask;
				fill_nx = fill - n_p;
				grant   = GRANT_W'(n_c);
			end
			default: begin
				grant = '0;
			end
		endcase
	end

	// hold writes while a read burst may still fetch slots behind the pointer
	assign in_ready = !q_full && !(is_write && (pend_q != '0));
	assign accept   = in_valid && in_ready;

	assign cmd_push        = accept;
	assign cmd_ctl.is_read = is_read;
	assign cmd_ctl.granted = grant;
	assign cmd_fill        = fill_nx;
	assign cmd_ptr         = rp_m;

	assign mem_we    = accept && is_write && !full;
	assign mem_waddr = wp_m;
	assign mem_wdata = write_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_LOG2_RESET;
			rp_q   <= '0;
			wp_q   <= '0;
			pend_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				size_q <= cfg_wr_data;
				rp_q   <= '0;
				wp_q   <= '0;
			end else if (accept) begin
				rp_q <= rp_nx;
				wp_q <= wp_nx;
			end
			if ((accept && is_read) && !rd_done) begin
				pend_q <= pend_q + 1'b1;
			end else if (rd_done && !(accept && is_read)) begin
				pend_q <= pend_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/prf_back.sv =====
// Back end of the ring FIFO: element storage, burst sequencing, memory read
// stage and output register. Depends on prf_pkg.
module prf_back #(
	parameter int PW = 10,
	parameter int EW = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	output logic                         q_pop,
	input  prf_pkg::cmd_ctl_t            cmd_ctl,
	input  logic [PW-1:0]                cmd_fill,
	input  logic [PW-1:0]                cmd_ptr,
	input  logic [PW-1:0]                ring_mask,
	input  logic                         mem_we,
	input  logic [PW-1:0]                mem_waddr,
	input  logic [EW-1:0]                mem_wdata,
	output logic                         rd_done,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [prf_pkg::GRANT_W-1:0]  granted,
	output logic [EW-1:0]                read_data,
	output logic                         data_valid,
	output logic                         last,
	output logic [PW-1:0]                fill_level
);
	import prf_pkg::*;

	logic [EW-1:0]      storage [1 << PW];

	logic               act_valid_q;
	logic               act_read_q;
	logic [GRANT_W-1:0] act_left_q;
	logic [GRANT_W-1:0] act_granted_q;
	logic [PW-1:0]      act_fill_q;
	logic [PW-1:0]      act_ptr_q;

	logic               valid_s1;
	logic               dv_s1;
	logic               last_s1;
	logic [GRANT_W-1:0] granted_s1;
	logic [PW-1:0]      fill_s1;
	logic [EW-1:0]      rdata_s1;

	logic               out_valid_q;
	logic               dv_q;
	logic               last_q;
	logic [GRANT_W-1:0] granted_q;
	logic [PW-1:0]      fill_q;
	logic [EW-1:0]      rdata_q;

	logic               out_free;
	logic               s1_go;
	logic               issue;
	logic               issue_last;

	assign out_free   = !out_valid_q || out_ready;
	assign s1_go      = valid_s1 && out_free;
	assign issue      = act_valid_q && (!valid_s1 || out_free);
	assign issue_last = !act_read_q || (act_left_q == GRANT_W'(1));
	assign q_pop      = q_valid && (!act_valid_q || (issue && issue_last));
	assign rd_done    = issue && issue_last && act_read_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			storage[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (issue && act_read_q) begin
			rdata_s1 <= storage[act_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_valid_q <= 1'b0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				act_valid_q <= 1'b1;
			end else if (issue && issue_last) begin
				act_valid_q <= 1'b0;
			end
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			act_read_q    <= cmd_ctl.is_read;
			act_left_q    <= cmd_ctl.granted;
			act_granted_q <= cmd_ctl.granted;
			act_fill_q    <= cmd_fill;
			act_ptr_q     <= cmd_ptr;
		end else if (issue) begin
			act_left_q <= act_left_q - 1'b1;
			act_ptr_q  <= (act_ptr_q + 1'b1) & ring_mask;
		end
		if (issue) begin
			dv_s1      <= act_read_q;
			last_s1    <= issue_last;
			granted_s1 <= act_granted_q;
			fill_s1    <= act_fill_q;
		end
		if (s1_go) begin
			dv_q      <= dv_s1;
			last_q    <= last_s1;
			granted_q <= granted_s1;
			fill_q    <= fill_s1;
			rdata_q   <= dv_s1 ? rdata_s1 : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign granted    = granted_q;
	assign read_data  = rdata_q;
	assign data_valid = dv_q;
	assign last       = last_q;
	assign fill_level = fill_q;

endmodule

// ===== hw/rtl/power_of_two_ring_fifo.sv =====
// Power-of-two ring FIFO, top level: front end, command queue, back end.
// Throughput: one item per cycle while the command queue has room; a read burst gives one
// element per cycle from the single storage read port unless the output stalls; a write
// waits while an earlier read burst is still fetching.
// Reset: size 2^10, both pointers zero, queue and output empty; storage is not cleared.
module power_of_two_ring_fifo #(
	parameter int DEPTH        = 1024,
	parameter int ELEMENT_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          func,
	input  logic [ELEMENT_BITS-1:0]             write_data,
	input  logic [prf_pkg::COUNT_W-1:0]         count,
	input  logic                                cfg_wr_en,
	input  logic [prf_pkg::SIZE_W-1:0]          cfg_wr_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [prf_pkg::GRANT_W-1:0]         granted,
	output logic [ELEMENT_BITS-1:0]             read_data,
	output logic                                data_valid,
	output logic                                last,
	output logic [$clog2(DEPTH + 1) - 2:0]      fill_level
);
	import prf_pkg::*;

	localparam int PW = $clog2(DEPTH + 1) - 1;
	localparam int QW = $bits(cmd_ctl_t) + 2 * PW;

	logic              q_full;
	logic              q_valid;
	logic              q_pop;
	logic              cmd_push;
	logic              rd_done;
	cmd_ctl_t          cmd_ctl;
	cmd_ctl_t          hd_ctl;
	logic [PW-1:0]     cmd_fill;
	logic [PW-1:0]     cmd_ptr;
	logic [PW-1:0]     hd_fill;
	logic [PW-1:0]     hd_ptr;
	logic [PW-1:0]     ring_mask;
	logic              mem_we;
	logic [PW-1:0]     mem_waddr;
	logic [ELEMENT_BITS-1:0] mem_wdata;
	logic [QW-1:0]     q_in;
	logic [QW-1:0]     q_head;

	prf_front #(
		.PW (PW),
		.EW (ELEMENT_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.write_data  (write_data),
		.count       (count),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_full      (q_full),
		.rd_done     (rd_done),
		.cmd_push    (cmd_push),
		.cmd_ctl     (cmd_ctl),
		.cmd_fill    (cmd_fill),
		.cmd_ptr     (cmd_ptr),
		.ring_mask   (ring_mask),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata)
	);

	assign q_in = {cmd_ctl, cmd_fill, cmd_ptr};

	prf_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.head_data (q_head)
	);

	assign {hd_ctl, hd_fill, hd_ptr} = q_head;

	prf_back #(
		.PW (PW),
		.EW (ELEMENT_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.cmd_ctl    (hd_ctl),
		.cmd_fill   (hd_fill),
		.cmd_ptr    (hd_ptr),
		.ring_mask  (ring_mask),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.rd_done    (rd_done),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.granted    (granted),
		.read_data  (read_data),
		.data_valid (data_valid),
		.last       (last),
		.fill_level (fill_level)
	);

endmodule
